>>> sv/w5ua_pkg.sv
// Shared widths, constants, types and the saturation helper for the WENO5 advection core.
package w5ua_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned N_SMP     = 7;
    localparam int unsigned N_DIFF    = 5;
    localparam int unsigned N_STEN    = 3;
    localparam int unsigned DIFF_W    = 33;
    localparam int unsigned PROD_SH   = 16;
    localparam int unsigned PM_W      = 48;
    localparam int unsigned CS_SH     = 8;
    localparam int unsigned CS_W      = 24;
    localparam int unsigned NM_W      = 37;
    localparam int unsigned NM_LO     = 18;
    localparam int unsigned PR_W      = 28;
    localparam int unsigned SQ_W      = 54;
    localparam int unsigned CSQ_W     = 47;
    localparam int unsigned EPSP_W    = 63;
    localparam int unsigned DIV_W     = 56;
    localparam int unsigned DIV_STEPS = 25;
    localparam int unsigned Q_SH      = 8;
    localparam int unsigned Q_W       = 17;
    localparam int unsigned AL_W      = 36;
    localparam int unsigned W_W       = 25;
    localparam int unsigned PL_W      = W_W + NM_LO;
    localparam int unsigned PH_W      = W_W + 1 + NM_W - NM_LO;
    localparam int unsigned ACC_W     = 64;
    localparam int unsigned Y_SH      = 25;
    localparam int unsigned Y_W       = ACC_W - Y_SH;
    localparam int unsigned YQ_W      = 33;

    localparam logic [15:0]        EPS_REL         = 16'd51540;
    localparam logic [31:0]        INV_SPACING_RST = 32'h0001_0000;
    localparam logic [W_W-1:0]     W_ONE           = 25'h100_0000;
    localparam logic [ACC_W-1:0]   DERIV_RND       = 64'h0000_0000_0300_0000;
    localparam logic [Y_W-1:0]     Y_SAT           = 39'h01_8000_0000;
    localparam logic [31:0]        THIRD_Q32       = 32'h5555_5555;
    localparam logic [ACC_W-1:0]   OUT_RND         = 64'h0000_0000_0080_0000;

    // register positions along the pipeline
    localparam int unsigned LAT    = 70;
    localparam int unsigned VC_DLY = 65;
    localparam int unsigned NM_DLY = 53;

    typedef logic signed [DATA_W-1:0] q24_t;
    typedef logic signed [NM_W-1:0]   nm_t;
    typedef logic [DIV_W-1:0]         divw_t;

    // magnitude plus sign to Q8.24, saturating
    function automatic q24_t sat_mag(input logic [63:0] mag, input logic neg);
        q24_t res;
        if (neg) begin
            if (mag >= 64'h0000_0000_8000_0000)
                res = q24_t'(32'h8000_0000);
            else
                res = q24_t'(~mag[31:0] + 32'd1);
        end
        else begin
            if (mag > 64'h0000_0000_7FFF_FFFF)
                res = q24_t'(32'h7FFF_FFFF);
            else
                res = q24_t'(mag[31:0]);
        end
        return res;
    endfunction

endpackage

>>> sv/w5ua_front.sv
// Front stages: centre velocity, upwind differences and inverse-spacing scaling.
module w5ua_front (
    input  logic                  clk,
    input  logic                  en,
    input  logic [31:0]           inv_spacing,
    input  w5ua_pkg::q24_t        smp [w5ua_pkg::N_SMP],
    input  w5ua_pkg::q24_t        face_here,
    input  w5ua_pkg::q24_t        face_prev,
    input  logic                  first,
    output w5ua_pkg::q24_t        dv [w5ua_pkg::N_DIFF],
    output w5ua_pkg::q24_t        vc
);

    logic signed [w5ua_pkg::DATA_W:0]   vsum;
    w5ua_pkg::q24_t                     vc_next;
    logic                               vpos;
    logic signed [w5ua_pkg::DIFF_W-1:0] d_next [w5ua_pkg::N_DIFF];
    logic signed [w5ua_pkg::DIFF_W-1:0] d_reg  [w5ua_pkg::N_DIFF];
    logic [w5ua_pkg::DIFF_W-1:0]        dmag   [w5ua_pkg::N_DIFF];
    logic [63:0]                        prod_full [w5ua_pkg::N_DIFF];
    logic [w5ua_pkg::PM_W-1:0]          prod_next [w5ua_pkg::N_DIFF];
    logic [w5ua_pkg::PM_W-1:0]          prod_reg  [w5ua_pkg::N_DIFF];
    logic [w5ua_pkg::N_DIFF-1:0]        neg_next, neg_reg;
    w5ua_pkg::q24_t                     dv_next [w5ua_pkg::N_DIFF];
    w5ua_pkg::q24_t                     dv_reg  [w5ua_pkg::N_DIFF];
    w5ua_pkg::q24_t                     vc1_reg, vc2_reg, vc3_reg;

    // floor of the face mean is an arithmetic shift of the 33-bit sum
    always_comb
    begin
        vsum    = {face_here[w5ua_pkg::DATA_W-1], face_here}
                + {face_prev[w5ua_pkg::DATA_W-1], face_prev};
        vc_next = first ? '0 : w5ua_pkg::q24_t'(vsum[w5ua_pkg::DATA_W:1]);
        vpos    = !vc_next[w5ua_pkg::DATA_W-1] && (vc_next != '0);
        for (int k = 0; k < w5ua_pkg::N_DIFF; k++)
        begin
            if (vpos)
                d_next[k] = w5ua_pkg::DIFF_W'(smp[k+1]) - w5ua_pkg::DIFF_W'(smp[k]);
            else
                d_next[k] = w5ua_pkg::DIFF_W'(smp[w5ua_pkg::N_SMP-1-k])
                          - w5ua_pkg::DIFF_W'(smp[w5ua_pkg::N_SMP-2-k]);
        end
    end

    // |d| stays below 2^32, so a 32x32 product covers it
    always_comb
    begin
        for (int k = 0; k < w5ua_pkg::N_DIFF; k++)
        begin
            neg_next[k]  = d_reg[k][w5ua_pkg::DIFF_W-1];
            dmag[k]      = neg_next[k] ? (~d_reg[k] + 1'b1) : d_reg[k];
            prod_full[k] = dmag[k][31:0] * inv_spacing;
            prod_next[k] = prod_full[k][63:w5ua_pkg::PROD_SH];
        end
    end

    always_comb
    begin
        for (int k = 0; k < w5ua_pkg::N_DIFF; k++)
            dv_next[k] = w5ua_pkg::sat_mag(64'(prod_reg[k]), neg_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < w5ua_pkg::N_DIFF; k++)
            begin
                d_reg[k]    <= d_next[k];
                prod_reg[k] <= prod_next[k];
                dv_reg[k]   <= dv_next[k];
            end
            neg_reg <= neg_next;
            vc1_reg <= vc_next;
            vc2_reg <= vc1_reg;
            vc3_reg <= vc2_reg;
        end
    end

    assign dv = dv_reg;
    assign vc = vc3_reg;

endmodule

>>> sv/w5ua_smooth.sv
// Candidate numerators, smoothness indicators, relative epsilon and the minimum indicator.
module w5ua_smooth (
    input  logic                  clk,
    input  logic                  en,
    input  w5ua_pkg::q24_t        dv [w5ua_pkg::N_DIFF],
    output w5ua_pkg::divw_t       t  [w5ua_pkg::N_STEN],
    output w5ua_pkg::divw_t       mn,
    output w5ua_pkg::nm_t         nm [w5ua_pkg::N_STEN]
);

    logic signed [w5ua_pkg::PR_W-1:0]   c [w5ua_pkg::N_DIFF];
    w5ua_pkg::nm_t                      x [w5ua_pkg::N_DIFF];
    w5ua_pkg::nm_t                      nm_next [w5ua_pkg::N_STEN];
    logic signed [w5ua_pkg::PR_W-1:0]   p_next [w5ua_pkg::N_STEN];
    logic signed [w5ua_pkg::PR_W-1:0]   r_next [w5ua_pkg::N_STEN];
    logic signed [w5ua_pkg::PR_W-1:0]   p_reg  [w5ua_pkg::N_STEN];
    logic signed [w5ua_pkg::PR_W-1:0]   r_reg  [w5ua_pkg::N_STEN];
    logic signed [w5ua_pkg::CS_W-1:0]   cs_reg [w5ua_pkg::N_DIFF];
    w5ua_pkg::nm_t                      nm_pipe_reg [6][w5ua_pkg::N_STEN];

    logic signed [2*w5ua_pkg::PR_W-1:0] pprod [w5ua_pkg::N_STEN];
    logic signed [2*w5ua_pkg::PR_W-1:0] rprod [w5ua_pkg::N_STEN];
    logic signed [2*w5ua_pkg::CS_W-1:0] cprod [w5ua_pkg::N_DIFF];
    logic [w5ua_pkg::SQ_W-1:0]          pp_reg [w5ua_pkg::N_STEN];
    logic [w5ua_pkg::SQ_W-1:0]          rr_reg [w5ua_pkg::N_STEN];
    logic [w5ua_pkg::CSQ_W-1:0]         csq_reg [w5ua_pkg::N_DIFF];

    w5ua_pkg::divw_t                    s12_next [w5ua_pkg::N_STEN];
    w5ua_pkg::divw_t                    s12_reg  [w5ua_pkg::N_STEN];
    w5ua_pkg::divw_t                    s12b_reg [w5ua_pkg::N_STEN];
    logic [w5ua_pkg::CSQ_W-1:0]         maxsq_next, maxsq_reg;
    logic [w5ua_pkg::EPSP_W-1:0]        epsp_reg;
    w5ua_pkg::divw_t                    t_next [w5ua_pkg::N_STEN];
    w5ua_pkg::divw_t                    t8_reg [w5ua_pkg::N_STEN];
    w5ua_pkg::divw_t                    t9_reg [w5ua_pkg::N_STEN];
    w5ua_pkg::divw_t                    mn_next, mn_reg;

    // stage 4: numerators (6x scaled) and the p/r terms of each stencil
    always_comb
    begin
        for (int k = 0; k < w5ua_pkg::N_DIFF; k++)
        begin
            x[k] = w5ua_pkg::nm_t'(dv[k]);
            c[k] = w5ua_pkg::PR_W'($signed(dv[k][w5ua_pkg::DATA_W-1:w5ua_pkg::CS_SH]));
        end
        nm_next[0] = (x[0] <<< 1) - ((x[1] <<< 3) - x[1]) + ((x[2] <<< 3) + (x[2] <<< 1) + x[2]);
        nm_next[1] = (x[2] <<< 2) + x[2] - x[1] + (x[3] <<< 1);
        nm_next[2] = (x[2] <<< 1) + (x[3] <<< 2) + x[3] - x[4];
        p_next[0]  = c[0] - (c[1] <<< 1) + c[2];
        r_next[0]  = c[0] - (c[1] <<< 2) + (c[2] <<< 1) + c[2];
        p_next[1]  = c[1] - (c[2] <<< 1) + c[3];
        r_next[1]  = c[1] - c[3];
        p_next[2]  = c[2] - (c[3] <<< 1) + c[4];
        r_next[2]  = (c[2] <<< 1) + c[2] - (c[3] <<< 2) + c[4];
    end

    // stage 5: squares
    always_comb
    begin
        for (int k = 0; k < w5ua_pkg::N_STEN; k++)
        begin
            pprod[k] = p_reg[k] * p_reg[k];
            rprod[k] = r_reg[k] * r_reg[k];
        end
        for (int k = 0; k < w5ua_pkg::N_DIFF; k++)
            cprod[k] = cs_reg[k] * cs_reg[k];
    end

    // stage 6: 12*S = 13p^2 + 3r^2, largest squared difference
    always_comb
    begin
        for (int k = 0; k < w5ua_pkg::N_STEN; k++)
            s12_next[k] = (w5ua_pkg::DIV_W'(pp_reg[k]) << 3) + (w5ua_pkg::DIV_W'(pp_reg[k]) << 2)
                        + w5ua_pkg::DIV_W'(pp_reg[k])
                        + (w5ua_pkg::DIV_W'(rr_reg[k]) << 1) + w5ua_pkg::DIV_W'(rr_reg[k]);
        maxsq_next = csq_reg[0];
        for (int k = 1; k < w5ua_pkg::N_DIFF; k++)
            if (csq_reg[k] > maxsq_next)
                maxsq_next = csq_reg[k];
    end

    // stage 8: add epsilon; stage 9: minimum
    always_comb
    begin
        for (int k = 0; k < w5ua_pkg::N_STEN; k++)
            t_next[k] = s12b_reg[k]
                      + w5ua_pkg::DIV_W'(epsp_reg[w5ua_pkg::EPSP_W-1:32]) + 1'b1;
        mn_next = t8_reg[0];
        if (t8_reg[1] < mn_next)
            mn_next = t8_reg[1];
        if (t8_reg[2] < mn_next)
            mn_next = t8_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < w5ua_pkg::N_STEN; k++)
            begin
                p_reg[k]          <= p_next[k];
                r_reg[k]          <= r_next[k];
                nm_pipe_reg[0][k] <= nm_next[k];
                for (int j = 1; j < 6; j++)
                    nm_pipe_reg[j][k] <= nm_pipe_reg[j-1][k];
                pp_reg[k]   <= pprod[k][w5ua_pkg::SQ_W-1:0];
                rr_reg[k]   <= rprod[k][w5ua_pkg::SQ_W-1:0];
                s12_reg[k]  <= s12_next[k];
                s12b_reg[k] <= s12_reg[k];
                t8_reg[k]   <= t_next[k];
                t9_reg[k]   <= t8_reg[k];
            end
            for (int k = 0; k < w5ua_pkg::N_DIFF; k++)
            begin
                cs_reg[k]  <= c[k][w5ua_pkg::CS_W-1:0];
                csq_reg[k] <= cprod[k][w5ua_pkg::CSQ_W-1:0];
            end
            maxsq_reg <= maxsq_next;
            epsp_reg  <= maxsq_reg * w5ua_pkg::EPS_REL;
            mn_reg    <= mn_next;
        end
    end

    assign t  = t9_reg;
    assign mn = mn_reg;
    assign nm = nm_pipe_reg[5];

endmodule

>>> sv/w5ua_div.sv
// Pipelined restoring divider: floor(num * 2^24 / den) for num <= den, one quotient bit per stage.
module w5ua_div (
    input  logic                            clk,
    input  logic                            en,
    input  w5ua_pkg::divw_t                 num,
    input  w5ua_pkg::divw_t                 den,
    output logic [w5ua_pkg::DIV_STEPS-1:0]  quo
);

    logic [w5ua_pkg::DIV_W:0]          sh   [w5ua_pkg::DIV_STEPS];
    w5ua_pkg::divw_t                   dn   [w5ua_pkg::DIV_STEPS];
    logic [w5ua_pkg::DIV_STEPS-1:0]    qp   [w5ua_pkg::DIV_STEPS];
    logic                              qb   [w5ua_pkg::DIV_STEPS];
    logic [w5ua_pkg::DIV_W:0]          rem_next [w5ua_pkg::DIV_STEPS];
    logic [w5ua_pkg::DIV_W:0]          rem_reg  [w5ua_pkg::DIV_STEPS];
    w5ua_pkg::divw_t                   den_reg  [w5ua_pkg::DIV_STEPS];
    logic [w5ua_pkg::DIV_STEPS-1:0]    q_next   [w5ua_pkg::DIV_STEPS];
    logic [w5ua_pkg::DIV_STEPS-1:0]    q_reg    [w5ua_pkg::DIV_STEPS];

    // first stage takes the integer bit without a shift
    always_comb
    begin
        sh[0] = {1'b0, num};
        dn[0] = den;
        qp[0] = '0;
        for (int i = 1; i < w5ua_pkg::DIV_STEPS; i++)
        begin
            sh[i] = {rem_reg[i-1][w5ua_pkg::DIV_W-1:0], 1'b0};
            dn[i] = den_reg[i-1];
            qp[i] = q_reg[i-1];
        end
        for (int i = 0; i < w5ua_pkg::DIV_STEPS; i++)
        begin
            qb[i]       = sh[i] >= {1'b0, dn[i]};
            rem_next[i] = qb[i] ? (sh[i] - {1'b0, dn[i]}) : sh[i];
            q_next[i]   = {qp[i][w5ua_pkg::DIV_STEPS-2:0], qb[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < w5ua_pkg::DIV_STEPS; i++)
            begin
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= dn[i];
                q_reg[i]   <= q_next[i];
            end
        end
    end

    assign quo = q_reg[w5ua_pkg::DIV_STEPS-1];

endmodule

>>> sv/weno5_upwind_advection_term_core.sv
// Top level of the fifth-order WENO upwind advection term pipeline.
// Takes one cell per beat (seven level-set samples, two face velocities,
// first-index flag on tuser) and returns velocity times the WENO5 derivative
// in Q8.24. Fully pipelined: one beat in and one beat out per cycle while
// the output is not stalled, through 70 register stages. Most of that
// depth is the two 25-stage restoring divider banks (stencil weights q_k,
// then normalized weights); the rest is multiplier and adder stages. The
// whole pipeline advances together; m_tready low freezes every stage
// only while a finished beat waits at the output register, and s_tready
// drops only then.
// inv_spacing (unsigned Q16.16, reset 1.0) is written on the cfg channel,
// which is always ready; write it only while the pipeline is empty.
module weno5_upwind_advection_term_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // low to high: sample_m3, sample_m2, sample_m1, sample_mid, sample_p1,
    // sample_p2, sample_p3, face_vel_here, face_vel_prev (32 bits each)
    input  logic [287:0] s_tdata,
    // at_first_index
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // advection_term
    output logic [31:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    logic                         en;
    logic [w5ua_pkg::LAT:1]       vld_reg, vld_next;
    logic [31:0]                  inv_spacing_reg, inv_spacing_next;

    w5ua_pkg::q24_t               smp [w5ua_pkg::N_SMP];
    w5ua_pkg::q24_t               face_here, face_prev;
    w5ua_pkg::q24_t               dv  [w5ua_pkg::N_DIFF];
    w5ua_pkg::q24_t               vc3;
    w5ua_pkg::divw_t              t9  [w5ua_pkg::N_STEN];
    w5ua_pkg::divw_t              mn9;
    w5ua_pkg::nm_t                nm9 [w5ua_pkg::N_STEN];
    logic [w5ua_pkg::DIV_STEPS-1:0] qa [w5ua_pkg::N_STEN];
    logic [w5ua_pkg::DIV_STEPS-1:0] wa, wb;

    w5ua_pkg::q24_t               vc_dly_reg [w5ua_pkg::VC_DLY];
    w5ua_pkg::nm_t                nm_dly_reg [w5ua_pkg::NM_DLY][w5ua_pkg::N_STEN];

    logic [w5ua_pkg::Q_W-1:0]     qk [w5ua_pkg::N_STEN];
    logic [2*w5ua_pkg::Q_W-1:0]   qsq [w5ua_pkg::N_STEN];
    logic [w5ua_pkg::AL_W-1:0]    al_next [w5ua_pkg::N_STEN];
    logic [w5ua_pkg::AL_W-1:0]    al_reg  [w5ua_pkg::N_STEN];
    logic [w5ua_pkg::AL_W-1:0]    al0b_reg, al1b_reg, total_reg;

    logic [w5ua_pkg::W_W-1:0]     w_next [w5ua_pkg::N_STEN];
    logic [w5ua_pkg::W_W-1:0]     w_reg  [w5ua_pkg::N_STEN];
    logic [w5ua_pkg::NM_LO-1:0]   nlo [w5ua_pkg::N_STEN];
    logic signed [w5ua_pkg::NM_W-w5ua_pkg::NM_LO-1:0] nhi [w5ua_pkg::N_STEN];
    logic signed [w5ua_pkg::W_W:0] ws [w5ua_pkg::N_STEN];
    logic [w5ua_pkg::PL_W-1:0]    pl_next [w5ua_pkg::N_STEN];
    logic [w5ua_pkg::PL_W-1:0]    pl_reg  [w5ua_pkg::N_STEN];
    logic signed [w5ua_pkg::PH_W-1:0] ph_next [w5ua_pkg::N_STEN];
    logic signed [w5ua_pkg::PH_W-1:0] ph_reg  [w5ua_pkg::N_STEN];
    logic signed [w5ua_pkg::ACC_W-1:0] lane_next [w5ua_pkg::N_STEN];
    logic signed [w5ua_pkg::ACC_W-1:0] lane_reg  [w5ua_pkg::N_STEN];
    logic signed [w5ua_pkg::ACC_W-1:0] acc_next, acc_reg;

    logic [w5ua_pkg::ACC_W-1:0]   amag, ysum;
    logic [w5ua_pkg::Y_W-1:0]     yv;
    logic [w5ua_pkg::YQ_W-1:0]    y_reg, yh_reg;
    logic                         ybig_reg, yneg_reg, ybig_h_reg, yneg_h_reg;
    logic [w5ua_pkg::YQ_W+31:0]   yprod_next, yprod_reg;
    logic [w5ua_pkg::YQ_W-1:0]    qe, qf;
    logic [w5ua_pkg::YQ_W+1:0]    rr;
    logic [63:0]                  dmag;
    w5ua_pkg::q24_t               deriv_next, deriv_reg;

    w5ua_pkg::q24_t               vc68;
    logic [31:0]                  mv, md;
    logic [63:0]                  vprod_next, vprod_reg;
    logic                         vsgn_next, vsgn_reg;
    logic [63:0]                  orsum;
    w5ua_pkg::q24_t               out_next, out_reg;

    // ---------------------------------------------------------------
    // Handshake and control: every stage moves unless the output stalls
    // ---------------------------------------------------------------
    assign en        = !vld_reg[w5ua_pkg::LAT] || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[w5ua_pkg::LAT];
    assign m_tdata   = out_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        vld_next         = {vld_reg[w5ua_pkg::LAT-1:1], s_tvalid};
        inv_spacing_next = cfg_valid ? cfg_data : inv_spacing_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= '0;
            inv_spacing_reg <= w5ua_pkg::INV_SPACING_RST;
        end
        else
        begin
            if (en)
                vld_reg <= vld_next;
            inv_spacing_reg <= inv_spacing_next;
        end
    end

    // ---------------------------------------------------------------
    // Beat unpack
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int k = 0; k < w5ua_pkg::N_SMP; k++)
            smp[k] = w5ua_pkg::q24_t'(s_tdata[k*w5ua_pkg::DATA_W +: w5ua_pkg::DATA_W]);
        face_here = w5ua_pkg::q24_t'(s_tdata[7*w5ua_pkg::DATA_W +: w5ua_pkg::DATA_W]);
        face_prev = w5ua_pkg::q24_t'(s_tdata[8*w5ua_pkg::DATA_W +: w5ua_pkg::DATA_W]);
    end

    // stages 1-3: centre velocity, upwind differences, scaling
    w5ua_front u_front (
        .clk         (clk),
        .en          (en),
        .inv_spacing (inv_spacing_reg),
        .smp         (smp),
        .face_here   (face_here),
        .face_prev   (face_prev),
        .first       (s_tuser),
        .dv          (dv),
        .vc          (vc3)
    );

    // stages 4-9: numerators, smoothness, epsilon, minimum
    w5ua_smooth u_smooth (
        .clk (clk),
        .en  (en),
        .dv  (dv),
        .t   (t9),
        .mn  (mn9),
        .nm  (nm9)
    );

    // stages 10-34: q_k = min / T_k in Q.16 (taken from a Q.24 quotient)
    for (genvar g = 0; g < w5ua_pkg::N_STEN; g++)
    begin : g_qdiv
        w5ua_div u_qdiv (
            .clk (clk),
            .en  (en),
            .num (mn9),
            .den (t9[g]),
            .quo (qa[g])
        );
    end

    // stage 35: alpha_k = c_k * q_k^2 with c = 1, 6, 3; stage 36: sum
    always_comb
    begin
        for (int k = 0; k < w5ua_pkg::N_STEN; k++)
        begin
            qk[k]  = qa[k][w5ua_pkg::DIV_STEPS-1:w5ua_pkg::Q_SH];
            qsq[k] = qk[k] * qk[k];
        end
        al_next[0] = w5ua_pkg::AL_W'(qsq[0]);
        al_next[1] = (w5ua_pkg::AL_W'(qsq[1]) << 2) + (w5ua_pkg::AL_W'(qsq[1]) << 1);
        al_next[2] = (w5ua_pkg::AL_W'(qsq[2]) << 1) + w5ua_pkg::AL_W'(qsq[2]);
    end

    // stages 37-61: normalized weights w1, w2
    w5ua_div u_wdiv_a (
        .clk (clk),
        .en  (en),
        .num (w5ua_pkg::DIV_W'(al0b_reg)),
        .den (w5ua_pkg::DIV_W'(total_reg)),
        .quo (wa)
    );

    w5ua_div u_wdiv_b (
        .clk (clk),
        .en  (en),
        .num (w5ua_pkg::DIV_W'(al1b_reg)),
        .den (w5ua_pkg::DIV_W'(total_reg)),
        .quo (wb)
    );

    // stage 62: w3 closes the sum to one; stage 63: split products
    always_comb
    begin
        w_next[0] = wa;
        w_next[1] = wb;
        w_next[2] = w5ua_pkg::W_ONE - wa - wb;
        for (int k = 0; k < w5ua_pkg::N_STEN; k++)
        begin
            nlo[k]     = nm_dly_reg[w5ua_pkg::NM_DLY-1][k][w5ua_pkg::NM_LO-1:0];
            nhi[k]     = nm_dly_reg[w5ua_pkg::NM_DLY-1][k][w5ua_pkg::NM_W-1:w5ua_pkg::NM_LO];
            ws[k]      = $signed({1'b0, w_reg[k]});
            pl_next[k] = w_reg[k] * nlo[k];
            ph_next[k] = ws[k] * nhi[k];
            // stage 64: recombine each lane
            lane_next[k] = (w5ua_pkg::ACC_W'(ph_reg[k]) <<< w5ua_pkg::NM_LO)
                         + $signed(w5ua_pkg::ACC_W'(pl_reg[k]));
        end
        // stage 65: weighted sum
        acc_next = lane_reg[0] + lane_reg[1] + lane_reg[2];
    end

    // stage 66: /(6*2^24) rounded half away from zero is
    // floor(floor((|acc| + 3*2^24) / 2^25) / 3)
    always_comb
    begin
        amag = acc_reg[w5ua_pkg::ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
        ysum = amag + w5ua_pkg::DERIV_RND;
        yv   = ysum[w5ua_pkg::ACC_W-1:w5ua_pkg::Y_SH];
    end

    // stage 67: reciprocal multiply; stage 68: one-step correction, saturate
    always_comb
    begin
        yprod_next = y_reg * w5ua_pkg::THIRD_Q32;
        qe         = yprod_reg[w5ua_pkg::YQ_W+31:32];
        rr         = {2'b00, yh_reg} - ({2'b00, qe} + {1'b0, qe, 1'b0});
        qf         = qe + w5ua_pkg::YQ_W'(rr >= 35'd3);
        dmag       = ybig_h_reg ? 64'h0000_0000_8000_0000 : 64'(qf);
        deriv_next = w5ua_pkg::sat_mag(dmag, yneg_h_reg);
    end

    // stage 69: velocity times derivative; stage 70: round to Q8.24
    always_comb
    begin
        vc68       = vc_dly_reg[w5ua_pkg::VC_DLY-1];
        mv         = vc68[31] ? (~vc68 + 1'b1) : vc68;
        md         = deriv_reg[31] ? (~deriv_reg + 1'b1) : deriv_reg;
        vprod_next = mv * md;
        vsgn_next  = vc68[31] ^ deriv_reg[31];
        orsum      = vprod_reg + w5ua_pkg::OUT_RND;
        out_next   = w5ua_pkg::sat_mag(orsum >> 24, vsgn_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vc_dly_reg[0] <= vc3;
            for (int j = 1; j < w5ua_pkg::VC_DLY; j++)
                vc_dly_reg[j] <= vc_dly_reg[j-1];
            for (int k = 0; k < w5ua_pkg::N_STEN; k++)
            begin
                nm_dly_reg[0][k] <= nm9[k];
                for (int j = 1; j < w5ua_pkg::NM_DLY; j++)
                    nm_dly_reg[j][k] <= nm_dly_reg[j-1][k];
                al_reg[k]   <= al_next[k];
                w_reg[k]    <= w_next[k];
                pl_reg[k]   <= pl_next[k];
                ph_reg[k]   <= ph_next[k];
                lane_reg[k] <= lane_next[k];
            end
            al0b_reg   <= al_reg[0];
            al1b_reg   <= al_reg[1];
            total_reg  <= al_reg[0] + al_reg[1] + al_reg[2];
            acc_reg    <= acc_next;
            y_reg      <= yv[w5ua_pkg::YQ_W-1:0];
            ybig_reg   <= yv >= w5ua_pkg::Y_SAT;
            yneg_reg   <= acc_reg[w5ua_pkg::ACC_W-1];
            yprod_reg  <= yprod_next;
            yh_reg     <= y_reg;
            ybig_h_reg <= ybig_reg;
            yneg_h_reg <= yneg_reg;
            deriv_reg  <= deriv_next;
            vprod_reg  <= vprod_next;
            vsgn_reg   <= vsgn_next;
            out_reg    <= out_next;
        end
    end

endmodule

>>> sv/w5ua_checker.sv
// Port-level checks for the WENO5 advection core, bound to the top level.
module w5ua_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata,
    input logic         cfg_ready
);

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output data changed while stalled");

    // input side stalls only behind a waiting output beat
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // configuration writes are never held off
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind weno5_upwind_advection_term_core w5ua_checker u_w5ua_checker (.*);
